>>> hdl/nlt_pkg.sv
package nlt_pkg;

   // Fixed field widths
   localparam int ROW_W      = 12;
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 12;
   localparam int CFG_R_W    = 4;
   localparam int CFG_K_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int KK_W       = 2 * CFG_K_W - 1;

   // Register reset values
   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);
   localparam logic [CFG_R_W-1:0] RADIUS_RESET = CFG_R_W'(7);
   localparam logic [CFG_K_W-1:0] K_RESET      = CFG_K_W'(-51);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_RADIUS = 2'd2,
      REG_K      = 2'd3
   } csr_index_type;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_PREP   = 12'b0000_0000_0010,
      ST_STORE  = 12'b0000_0000_0100,
      ST_CHECK  = 12'b0000_0000_1000,
      ST_OFFSET = 12'b0000_0001_0000,
      ST_SWEEP  = 12'b0000_0010_0000,
      ST_TAIL   = 12'b0000_0100_0000,
      ST_MUL1   = 12'b0000_1000_0000,
      ST_MUL2   = 12'b0001_0000_0000,
      ST_MUL3   = 12'b0010_0000_0000,
      ST_MUL4   = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } nlt_state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic store;
      logic check;
      logic offset;
      logic sweep;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic deliver;
   } nlt_cmd_type;

   typedef struct packed {
      logic due;
      logic sweep_last;
      logic out_busy;
   } nlt_status_type;

endpackage

>>> hdl/nlt_if.sv
interface nlt_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] pixel;
   modport source (output valid, mode, pixel, input ready);
   modport sink (input valid, mode, pixel, output ready);
endinterface

interface nlt_rsp_if;
   logic valid;
   logic ready;
   logic out_white;
   logic end_of_frame;
   modport source (output valid, out_white, end_of_frame, input ready);
   modport sink (input valid, out_white, end_of_frame, output ready);
endinterface

>>> hdl/nlt_ram.sv
module nlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/nlt_controller.sv
module nlt_controller import nlt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  nlt_status_type status,
   output nlt_cmd_type    cmd
);

   nlt_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = ST_STORE;
         ST_STORE:  state_in = ST_CHECK;
         ST_CHECK:  state_in = status.due ? ST_OFFSET : ST_IDLE;
         ST_OFFSET: state_in = ST_SWEEP;
         ST_SWEEP:  if (status.sweep_last) state_in = ST_TAIL;
         ST_TAIL:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_MUL3;
         ST_MUL3:   state_in = ST_MUL4;
         ST_MUL4:   state_in = ST_DONE;
         ST_DONE:   if (!status.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode commands
   always_comb begin
      cmd         = '0;
      cmd.accept  = (state_ff == ST_IDLE) && req_valid;
      cmd.prep    = (state_ff == ST_PREP);
      cmd.store   = (state_ff == ST_STORE);
      cmd.check   = (state_ff == ST_CHECK) && status.due;
      cmd.offset  = (state_ff == ST_OFFSET);
      cmd.sweep   = (state_ff == ST_SWEEP);
      cmd.mul1    = (state_ff == ST_MUL1);
      cmd.mul2    = (state_ff == ST_MUL2);
      cmd.mul3    = (state_ff == ST_MUL3);
      cmd.mul4    = (state_ff == ST_MUL4);
      cmd.deliver = (state_ff == ST_DONE) && !status.out_busy;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

>>> hdl/nlt_datapath.sv
module nlt_datapath import nlt_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  nlt_cmd_type           cmd,
   output nlt_status_type        status,
   input  logic                  req_mode,
   input  logic [7:0]            req_pixel,
   output logic                  rsp_valid,
   output logic                  rsp_out_white,
   output logic                  rsp_end_of_frame,
   input  logic                  rsp_ready
);

   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int SPAN = 2 * MAX_RADIUS + 1;
   localparam int RING = MAX_WIDTH * SPAN;
   localparam int AW   = $clog2(RING);
   localparam int NW   = $clog2(SPAN * SPAN + 1);
   localparam int SW   = NW + 8;
   localparam int QW   = NW + 16;
   localparam int DW   = NW + 16;
   localparam int VW   = 2 * NW + 16;
   localparam int VL   = VW / 2;
   localparam int RHW  = KK_W + VW;
   localparam int CNTW = WW + ROW_W;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (AW+1)'(RING)) s = s - (AW+1)'(RING);
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      if (a >= b) s = {1'b0, a} - {1'b0, b};
      else s = {1'b0, a} + (AW+1)'(RING) - {1'b0, b};
      return s[AW-1:0];
   endfunction

   // Configuration registers
   logic [CFG_W_W-1:0] cfg_width_ff;
   logic [CFG_H_W-1:0] cfg_height_ff;
   logic [CFG_R_W-1:0] cfg_radius_ff;
   logic [CFG_K_W-1:0] cfg_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
         cfg_radius_ff <= RADIUS_RESET;
         cfg_k_ff      <= K_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_WIDTH:  cfg_width_ff  <= csr_write_data[CFG_W_W-1:0];
            REG_HEIGHT: cfg_height_ff <= csr_write_data[CFG_H_W-1:0];
            REG_RADIUS: cfg_radius_ff <= csr_write_data[CFG_R_W-1:0];
            REG_K:      cfg_k_ff      <= csr_write_data[CFG_K_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp configuration to the supported range
   logic [WW-1:0]    w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [RW-1:0]    r_eff;

   always_comb begin
      if (cfg_width_ff == '0) w_eff = WW'(1);
      else if (32'(cfg_width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(cfg_width_ff);
      h_eff = (cfg_height_ff == '0) ? ROW_W'(1) : cfg_height_ff;
      r_eff = (32'(cfg_radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius_ff);
   end

   // Latched input item and frame constants
   logic             mode_ff;
   logic [7:0]       pixel_ff;
   logic [CNTW-1:0]  total_ff, lag_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         pixel_ff <= req_pixel;
      end
      if (cmd.prep) begin
         total_ff <= CNTW'(w_eff) * CNTW'(h_eff);
         lag_ff   <= CNTW'(r_eff) * CNTW'(w_eff) + CNTW'(r_eff);
      end
   end

   // Raster positions
   logic [ROW_W-1:0] in_row_ff, out_row_ff;
   logic [CW-1:0]    in_col_ff, out_col_ff;
   logic [AW-1:0]    wr_addr_ff, out_addr_ff;
   logic [CNTW-1:0]  rx_cnt_ff, tx_cnt_ff;
   logic             store_ok;
   logic [WW-1:0]    in_col_nx, out_col_nx;
   logic             last;

   assign store_ok   = cmd.store && !mode_ff && (in_row_ff < h_eff);
   assign in_col_nx  = WW'(in_col_ff) + WW'(1);
   assign out_col_nx = WW'(out_col_ff) + WW'(1);
   assign last       = (tx_cnt_ff + CNTW'(1)) == total_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable || (cmd.deliver && last)) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         wr_addr_ff  <= '0;
         rx_cnt_ff   <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_addr_ff <= '0;
         tx_cnt_ff   <= '0;
      end else begin
         // Advance input position
         if (store_ok) begin
            if (in_col_nx >= w_eff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + ROW_W'(1);
            end else begin
               in_col_ff <= in_col_nx[CW-1:0];
            end
            wr_addr_ff <= ring_add(wr_addr_ff, AW'(1));
            rx_cnt_ff  <= rx_cnt_ff + CNTW'(1);
         end
         // Advance result position
         if (cmd.deliver) begin
            if (out_col_nx >= w_eff) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + ROW_W'(1);
            end else begin
               out_col_ff <= out_col_nx[CW-1:0];
            end
            out_addr_ff <= ring_add(out_addr_ff, AW'(1));
            tx_cnt_ff   <= tx_cnt_ff + CNTW'(1);
         end
      end
   end

   // Result due when enough input arrived or the frame input is complete
   assign status.due = (tx_cnt_ff < total_ff) &&
                       ((rx_cnt_ff >= total_ff) ||
                        ({1'b0, rx_cnt_ff} >= {1'b0, tx_cnt_ff} + {1'b0, lag_ff} + (CNTW+1)'(1)));

   // Clipped window bounds
   logic [ROW_W-1:0]     r0, r1, dr;
   logic [ROW_W:0]       r1_sum;
   logic [WW:0]          oc, rr, c0w, c1w;
   logic [ROW_W+WW-1:0]  row_off;
   logic [AW-1:0]        offset_in;

   always_comb begin
      r0     = (out_row_ff >= ROW_W'(r_eff)) ? out_row_ff - ROW_W'(r_eff) : '0;
      r1_sum = {1'b0, out_row_ff} + (ROW_W+1)'(r_eff);
      r1     = (r1_sum < {1'b0, h_eff}) ? r1_sum[ROW_W-1:0] : h_eff - ROW_W'(1);
      oc     = (WW+1)'(out_col_ff);
      rr     = (WW+1)'(r_eff);
      c0w    = (oc >= rr) ? oc - rr : '0;
      c1w    = (oc + rr < (WW+1)'(w_eff)) ? oc + rr : (WW+1)'(w_eff) - (WW+1)'(1);
      dr     = out_row_ff - r0;
      row_off   = (ROW_W+WW)'(dr) * (ROW_W+WW)'(w_eff);
      offset_in = AW'(row_off) + AW'(oc - c0w);
   end

   logic [ROW_W-1:0] r1_ff, row_ff, r0_ff;
   logic [CW-1:0]    c0_ff, c1_ff, col_ff;
   logic [AW-1:0]    offset_ff, row_addr_ff, cur_addr_ff, next_row_addr;
   logic             pending_ff;
   logic [NW-1:0]    n_ff;
   logic [SW-1:0]    s_ff;
   logic [QW-1:0]    q_ff;
   logic [7:0]       p_ff;
   logic [7:0]       rd_data;
   logic [15:0]      rd_sq;
   logic             row_end;

   assign row_end           = (col_ff == c1_ff);
   assign status.sweep_last = row_end && (row_ff == r1_ff);
   assign next_row_addr     = ring_add(row_addr_ff, AW'(w_eff));
   assign rd_sq             = 16'(rd_data) * 16'(rd_data);

   always_ff @(posedge clock) begin
      // Hold bounds
      if (cmd.check) begin
         r0_ff     <= r0;
         r1_ff     <= r1;
         c0_ff     <= c0w[CW-1:0];
         c1_ff     <= c1w[CW-1:0];
         offset_ff <= offset_in;
      end
      // Set up the sweep from the window corner
      if (cmd.offset) begin
         p_ff        <= rd_data;
         row_addr_ff <= ring_sub(out_addr_ff, offset_ff);
         cur_addr_ff <= ring_sub(out_addr_ff, offset_ff);
         row_ff      <= r0_ff;
         col_ff      <= c0_ff;
         n_ff        <= '0;
         s_ff        <= '0;
         q_ff        <= '0;
      end else if (pending_ff) begin
         n_ff <= n_ff + NW'(1);
         s_ff <= s_ff + SW'(rd_data);
         q_ff <= q_ff + QW'(rd_sq);
      end
      // Step through the window
      if (cmd.sweep) begin
         if (row_end) begin
            col_ff      <= c0_ff;
            row_ff      <= row_ff + ROW_W'(1);
            row_addr_ff <= next_row_addr;
            cur_addr_ff <= next_row_addr;
         end else begin
            col_ff      <= col_ff + CW'(1);
            cur_addr_ff <= ring_add(cur_addr_ff, AW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= cmd.sweep;
      end
   end

   // Line store
   nlt_ram #(
      .WIDTH (8),
      .DEPTH (RING)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_ok),
      .wr_addr (wr_addr_ff),
      .wr_data (pixel_ff),
      .rd_en   (cmd.check || cmd.sweep),
      .rd_addr (cmd.check ? out_addr_ff : cur_addr_ff),
      .rd_data (rd_data)
   );

   // Squared-term comparison, one product stage per cycle
   logic [SW-1:0]              np_ff;
   logic [VW-1:0]              s2_ff, nq_ff, v_ff;
   logic [KK_W-1:0]            kk_ff;
   logic signed [2*CFG_K_W-1:0] k_sq;
   logic [SW:0]                dif;
   logic [SW-1:0]              mag;
   logic                       dneg_ff;
   logic [DW-1:0]              ad_ff;
   logic [2*DW-1:0]            dd_ff;
   logic [KK_W+VL-1:0]         plo_ff;
   logic [RHW-1:0]             rhs_ff, phi;
   logic                       k_neg, white;

   assign k_sq  = $signed(cfg_k_ff) * $signed(cfg_k_ff);
   assign dif   = {1'b0, np_ff} - {1'b0, s_ff};
   assign mag   = dif[SW] ? SW'(-dif) : dif[SW-1:0];
   assign phi   = RHW'(kk_ff) * RHW'(v_ff[VW-1:VL]);
   assign k_neg = cfg_k_ff[CFG_K_W-1];

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         np_ff <= SW'(n_ff) * SW'(p_ff);
         s2_ff <= VW'(s_ff) * VW'(s_ff);
         nq_ff <= VW'(n_ff) * VW'(q_ff);
         kk_ff <= k_sq[KK_W-1:0];
      end
      if (cmd.mul2) begin
         dneg_ff <= dif[SW];
         ad_ff   <= {mag, 8'd0};
         v_ff    <= (nq_ff >= s2_ff) ? nq_ff - s2_ff : '0;
      end
      if (cmd.mul3) begin
         dd_ff  <= (2*DW)'(ad_ff) * (2*DW)'(ad_ff);
         plo_ff <= (KK_W+VL)'(kk_ff) * (KK_W+VL)'(v_ff[VL-1:0]);
      end
      if (cmd.mul4) begin
         rhs_ff <= RHW'(plo_ff) + (phi << VL);
      end
   end

   always_comb begin
      if (!k_neg) white = !dneg_ff && (RHW'(dd_ff) >= rhs_ff);
      else white = !dneg_ff || (RHW'(dd_ff) <= rhs_ff);
   end

   // Output register
   logic rsp_valid_ff, rsp_white_ff, rsp_eof_ff;

   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_white_ff <= white;
         rsp_eof_ff   <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_white    = rsp_white_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

>>> hdl/niblack_local_threshold_unit.sv
// Niblack local thresholding of a raster stream of 8-bit grey pixels.
// req_ch carries one item per transfer: mode 0 is a pixel, mode 1 a drain
// tick. rsp_ch carries one binary pixel per transfer (out_white) with
// end_of_frame on the last pixel of the frame. Results trail the input by
// r rows plus r pixels; once the frame is in, drain ticks flush the rest.
// The csr_ port writes width, height, radius and k (index 0 to 3); the user
// must write them only while the block is idle, a rule the block itself
// leaves unenforced; any write restarts the frame. An item is taken only
// once the engine is through with the last one. For an item that yields a
// result, the clipped window of up to (2r+1)^2 pixels is summed one pixel
// per cycle through the single read port of the line store, followed by
// four product stages of the squared comparison.
// Reset clears positions and loads default registers; the line store
// needs no clearing since it is read only where written in the frame.
// A result waits in an output register; the next item is still accepted,
// and only a further result stalls until the receiver takes the first.
module niblack_local_threshold_unit import nlt_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   nlt_req_if.sink               req_ch,
   nlt_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   nlt_cmd_type    cmd;
   nlt_status_type status;

   nlt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nlt_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_ch.mode),
      .req_pixel        (req_ch.pixel),
      .rsp_valid        (rsp_ch.valid),
      .rsp_out_white    (rsp_ch.out_white),
      .rsp_end_of_frame (rsp_ch.end_of_frame),
      .rsp_ready        (rsp_ch.ready)
   );

   // One item at a time: the engine is busy right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input accepted while engine busy");

   // A new result is loaded only while the engine is working on an item
   a_result_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result loaded while engine idle");

   // A fresh transfer cannot produce a result within the setup cycles
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !$rose(rsp_ch.valid))
      else $error("result appeared too early");

endmodule

>>> tb/niblack_local_threshold_unit_tb.sv
`timescale 1ns / 100ps

module niblack_local_threshold_unit_tb;
   import nlt_pkg::*;

   localparam int MAX_W    = 1024;
   localparam int MAX_R    = 15;
   localparam int RING     = MAX_W * (2 * MAX_R + 1);
   localparam int ITEM_GOAL = 800;

   typedef struct {
      bit white;
      bit eof;
   } binary_pixel_t;

   typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

   typedef struct {
      row_kind_t     kind;
      csr_index_type idx;
      int            data;
      bit            mode;
      int            pixel;
      bit            typed;
      bit            exp_white;
      bit            exp_eof;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   nlt_req_if req_ch ();
   nlt_rsp_if rsp_ch ();

   niblack_local_threshold_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // Shadow state of the thresholding unit
   logic [7:0] ring_pixels [RING];
   int unsigned cfg_width, cfg_height, cfg_radius;
   int          cfg_k;
   int unsigned in_r, in_c, out_r, out_c;

   binary_pixel_t pending_pixels [$];
   int  mismatch_count = 0;
   int  item_count = 0;
   bit  quiet = 1'b0;

   function automatic int unsigned eff_w();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_h();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic int unsigned eff_r();
      return (cfg_radius > MAX_R) ? MAX_R : cfg_radius;
   endfunction

   function automatic void restart_frame();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
   endfunction

   function automatic void apply_csr(csr_index_type idx, int unsigned value);
      case (idx)
         REG_WIDTH:  cfg_width  = value & 'h7FF;
         REG_HEIGHT: cfg_height = value & 'hFFF;
         REG_RADIUS: cfg_radius = value & 'hF;
         REG_K: begin
            cfg_k = value & 'h7FF;
            if (cfg_k >= 1024) cfg_k = cfg_k - 2048;
         end
         default: ;
      endcase
      restart_frame();
   endfunction

   function automatic longint unsigned ring_at(int unsigned row, int unsigned col,
                                               int unsigned w);
      return ring_pixels[(row * w + col) % RING];
   endfunction

   // Exact Niblack decision on the clipped window around (orow, ocol)
   function automatic bit niblack_white(int unsigned orow, int unsigned ocol,
                                        int unsigned w, int unsigned h, int unsigned r);
      int unsigned r0, r1, c0, c1;
      longint n, s, q, d, v, b, p;
      longint unsigned dd, kk, rhs;
      r0 = (orow >= r) ? orow - r : 0;
      r1 = (orow + r < h) ? orow + r : h - 1;
      c0 = (ocol >= r) ? ocol - r : 0;
      c1 = (ocol + r < w) ? ocol + r : w - 1;
      n = 0; s = 0; q = 0;
      p = ring_at(orow, ocol, w);
      for (int unsigned rr = r0; rr <= r1; rr++)
         for (int unsigned cc = c0; cc <= c1; cc++) begin
            b = ring_at(rr, cc, w);
            n++; s += b; q += b * b;
         end
      d = 256 * (n * p - s);
      v = n * q - s * s;
      if (v < 0) v = 0;
      dd = (d < 0) ? -d : d;
      dd = dd * dd;
      kk = longint'(cfg_k) * longint'(cfg_k);
      rhs = kk * longint'(v);
      if (cfg_k >= 0) begin
         if (d < 0) return 1'b0;
         return dd >= rhs;
      end
      if (d >= 0) return 1'b1;
      return dd <= rhs;
   endfunction

   // Advance the shadow state by one accepted item
   function automatic bit threshold_step(bit mode, logic [7:0] pix,
                                         output binary_pixel_t res);
      int unsigned w, h, r, total, lag, received, produced;
      w = eff_w(); h = eff_h(); r = eff_r();
      total = w * h;
      lag = r * w + r;
      if (in_r >= h) begin
         in_r = h; in_c = 0;
      end
      if (out_r >= h) restart_frame();
      if (mode == 1'b0 && in_r < h) begin
         ring_pixels[(in_r * w + in_c) % RING] = pix;
         in_c++;
         if (in_c >= w) begin
            in_c = 0; in_r++;
         end
      end
      received = in_r * w + in_c;
      produced = out_r * w + out_c;
      if (produced >= total) return 1'b0;
      if (received < total && received < produced + lag + 1) return 1'b0;
      res.white = niblack_white(out_r, out_c, w, h, r);
      res.eof = (produced + 1 == total);
      out_c++;
      if (out_c >= w) begin
         out_c = 0; out_r++;
      end
      if (res.eof) restart_frame();
      return 1'b1;
   endfunction

   // Hold valid for one transfer after a random gap, then predict
   task automatic send_item(bit mode, logic [7:0] pix, bit typed = 1'b0,
                            bit t_white = 1'b0, bit t_eof = 1'b0);
      int gap;
      binary_pixel_t res;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= mode;
      req_ch.pixel <= pix;
      do @(posedge clock); while (!req_ch.ready);
      item_count++;
      if (threshold_step(mode, pix, res)) begin
         if (typed) begin
            res.white = t_white;
            res.eof = t_eof;
         end
         pending_pixels.push_back(res);
      end
   endtask

   // Drop valid, wait out all results plus the no-result latency, then write
   task automatic write_csr(csr_index_type idx, int unsigned value);
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      apply_csr(idx, value);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned r, int k);
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
      write_csr(REG_RADIUS, r);
      write_csr(REG_K, k & 'h7FF);
   endtask

   // Pixel stream of one frame with noise; a full frame is drained to its end
   task automatic run_frame(int unsigned limit_pixels);
      int unsigned sent;
      sent = 0;
      while (sent < limit_pixels) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'b1, 8'($urandom));
         end else begin
            send_item(1'b0, 8'($urandom));
            sent++;
         end
      end
      while (limit_pixels == eff_w() * eff_h() && (out_r != 0 || out_c != 0 || in_r != 0))
         send_item($urandom_range(0, 3) != 0, 8'($urandom));
   endtask

   // Accept results with random stalls, check against the oldest prediction
   initial begin
      int gap;
      binary_pixel_t want;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result white=%0b eof=%0b", $time,
                     rsp_ch.out_white, rsp_ch.end_of_frame);
         end else begin
            want = pending_pixels.pop_front();
            if (want.white !== rsp_ch.out_white || want.eof !== rsp_ch.end_of_frame) begin
               mismatch_count++;
               $display("%0t: expected white=%0b eof=%0b, got white=%0b eof=%0b", $time,
                        want.white, want.eof, rsp_ch.out_white, rsp_ch.end_of_frame);
            end
         end
      end
   end

   stim_row_t stim_rows [] = '{
      '{ROW_CFG,  REG_WIDTH,  1,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_HEIGHT, 1,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_RADIUS, 0,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_K,      0,    0, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 0,   1, 1, 1},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 255, 1, 1, 1},
      '{ROW_ITEM, REG_WIDTH,  0,    1, 0,   0, 0, 0},
      '{ROW_CFG,  REG_K,      1024, 0, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 255, 1, 1, 1},
      '{ROW_CFG,  REG_K,      1023, 0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_WIDTH,  0,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_HEIGHT, 0,    0, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 128, 1, 1, 1},
      '{ROW_CFG,  REG_WIDTH,  3,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_HEIGHT, 2,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_RADIUS, 1,    0, 0,   0, 0, 0},
      '{ROW_CFG,  REG_K,      2047, 0, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    1, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 255, 0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 17,  0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 200, 0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 255, 0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    0, 99,  0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    1, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    1, 0,   0, 0, 0},
      '{ROW_ITEM, REG_WIDTH,  0,    1, 0,   0, 0, 0}
   };

   initial begin
      int unsigned w, h, r;
      int k, phase;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= 1'b0;
      req_ch.pixel     <= 8'd0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_WIDTH;
      csr_write_data   <= '0;
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_radius = RADIUS_RESET;
      cfg_k      = -51;
      restart_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CFG)
            write_csr(stim_rows[i].idx, stim_rows[i].data);
         else
            send_item(stim_rows[i].mode, 8'(stim_rows[i].pixel), stim_rows[i].typed,
                      stim_rows[i].exp_white, stim_rows[i].exp_eof);
      end

      // Extreme settings: widest row and tallest frame, both cut short
      configure(2047, 2, 0, -1024);
      run_frame(160);
      configure(1, 4095, 15, 1023);
      run_frame(60);

      // Random small frames, mostly complete, some cut short
      phase = 0;
      while (item_count < ITEM_GOAL) begin
         quiet = ($urandom_range(0, 4) == 0);
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 12);
         r = $urandom_range(0, 15);
         k = $urandom_range(0, 2047) - 1024;
         if (phase % 5 == 0) k = ($urandom_range(0, 1) != 0) ? 1023 : -1024;
         if (phase % 7 == 3) k = 0;
         configure(w, h, r, k);
         if ($urandom_range(0, 7) == 0)
            run_frame($urandom_range(0, w * h - 1));
         else
            run_frame(w * h);
         phase++;
      end

      // Restore the power-up settings, then close out
      configure(640, 480, 7, -51);
      quiet = 1'b0;
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #60ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
